// File: src/rtp_pkg.sv
// ----------------------------------------------------------------------------
// Rectangular to polar package
// Widths, stage counts, angle constants and the arctangent table shared by
// the rectangular to polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int ITERATIONS = 16;
  localparam int ANGLE_W    = 16;

  // Input magnitude width, sum of squares width and square root remainder width.
  localparam int AW = DATA_WIDTH + 1;
  localparam int SW = 2 * DATA_WIDTH;
  localparam int RW = DATA_WIDTH + 4;

  // Rotator coordinate width and angle accumulator width.
  localparam int SCALE = 60 - DATA_WIDTH;
  localparam int CW    = 62;
  localparam int ZW    = 34;

  localparam int SQRT_STEPS = DATA_WIDTH;
  localparam int NSTG       = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

  localparam int QSHIFT = 17;
  localparam logic signed [ZW-1:0]      HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0]      ROUND_Q13   = 34'sd65536;
  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic zero;
    logic im_zero;
    logic re_pos;
    logic im_neg;
  } flags_t;

endpackage

`default_nettype wire

// File: src/rectangular_to_polar_core.sv
// ----------------------------------------------------------------------------
// Rectangular to polar converter
// Converts a complex sample to its rounded magnitude and its Q3.13 angle.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. The
// block is fully pipelined, so busy stays low and an item may be sent every
// cycle. Each item carries in_real_part and in_imag_part as signed integers.
//
// An input register stage, a squaring stage, a stage that adds the squares and
// seeds the rotator, then one stage per rotation step or root digit, whichever
// count is larger, and one output stage. One result leaves per cycle at a
// sustained rate of one item per cycle.
//
// Each result is shown for one cycle with out_valid high. The receiver cannot
// stall the block and must take every result in the cycle it is shown.
// Reset clears every valid bit, so items in flight are dropped and no result
// is shown until new items arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangular_to_polar_core (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic signed [rtp_pkg::DATA_WIDTH-1:0]      in_real_part,
  input  logic signed [rtp_pkg::DATA_WIDTH-1:0]      in_imag_part,
  output logic                                       out_valid,
  output logic        [rtp_pkg::DATA_WIDTH-1:0]      out_magnitude,
  output logic signed [rtp_pkg::ANGLE_W-1:0]         out_angle
);

  localparam int DW      = rtp_pkg::DATA_WIDTH;
  localparam int AW      = rtp_pkg::AW;
  localparam int SW      = rtp_pkg::SW;
  localparam int RW      = rtp_pkg::RW;
  localparam int CW      = rtp_pkg::CW;
  localparam int ZW      = rtp_pkg::ZW;
  localparam int NSTG    = rtp_pkg::NSTG;
  localparam int ANGLE_W = rtp_pkg::ANGLE_W;

  // Input stage.
  logic                  a_v_r;
  logic [AW-1:0]         a_are_r;
  logic [AW-1:0]         a_aim_r;
  logic                  a_re_neg_r;
  rtp_pkg::flags_t       a_flags_r;

  logic signed [AW-1:0]  re_ext;
  logic signed [AW-1:0]  im_ext;
  logic [AW-1:0]         are_nxt;
  logic [AW-1:0]         aim_nxt;
  rtp_pkg::flags_t       flags_nxt;

  assign busy = 1'b0;

  always_comb begin
    re_ext            = {in_real_part[DW-1], in_real_part};
    im_ext            = {in_imag_part[DW-1], in_imag_part};
    are_nxt           = in_real_part[DW-1] ? AW'(-re_ext) : AW'(re_ext);
    aim_nxt           = in_imag_part[DW-1] ? AW'(-im_ext) : AW'(im_ext);
    flags_nxt.zero    = (in_real_part == '0) && (in_imag_part == '0);
    flags_nxt.im_zero = (in_imag_part == '0);
    flags_nxt.re_pos  = !in_real_part[DW-1] && (in_real_part != '0);
    flags_nxt.im_neg  = in_imag_part[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_are_r    <= are_nxt;
    a_aim_r    <= aim_nxt;
    a_re_neg_r <= in_real_part[DW-1];
    a_flags_r  <= flags_nxt;
  end

  // Squaring stage.
  logic                  b_v_r;
  logic [SW-1:0]         b_sq_re_r;
  logic [SW-1:0]         b_sq_im_r;
  logic [AW-1:0]         b_are_r;
  logic [AW-1:0]         b_aim_r;
  logic                  b_re_neg_r;
  rtp_pkg::flags_t       b_flags_r;

  logic [2*AW-1:0]       sq_re_nxt;
  logic [2*AW-1:0]       sq_im_nxt;

  assign sq_re_nxt = a_are_r * a_are_r;
  assign sq_im_nxt = a_aim_r * a_aim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_sq_re_r  <= sq_re_nxt[SW-1:0];
    b_sq_im_r  <= sq_im_nxt[SW-1:0];
    b_are_r    <= a_are_r;
    b_aim_r    <= a_aim_r;
    b_re_neg_r <= a_re_neg_r;
    b_flags_r  <= a_flags_r;
  end

  // Step pipeline; index 0 holds the sum of squares and the rotator seed.
  logic                  s_v_r    [0:NSTG];
  logic signed [CW-1:0]  s_x_r    [0:NSTG];
  logic signed [CW-1:0]  s_y_r    [0:NSTG];
  logic signed [ZW-1:0]  s_z_r    [0:NSTG];
  logic [SW-1:0]         s_rad_r  [0:NSTG];
  logic [RW-1:0]         s_rem_r  [0:NSTG];
  logic [DW-1:0]         s_root_r [0:NSTG];
  rtp_pkg::flags_t       s_f_r    [0:NSTG];

  logic signed [CW-1:0]  x0_nxt;
  logic signed [CW-1:0]  y0_nxt;
  logic signed [ZW-1:0]  z0_nxt;

  always_comb begin
    if (b_re_neg_r) begin
      x0_nxt = $signed(CW'(b_aim_r) << rtp_pkg::SCALE);
      y0_nxt = $signed(CW'(b_are_r) << rtp_pkg::SCALE);
      z0_nxt = rtp_pkg::HALF_PI_Q30;
    end else begin
      x0_nxt = $signed(CW'(b_are_r) << rtp_pkg::SCALE);
      y0_nxt = $signed(CW'(b_aim_r) << rtp_pkg::SCALE);
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r[0] <= 1'b0;
    end else begin
      s_v_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s_x_r[0]    <= x0_nxt;
    s_y_r[0]    <= y0_nxt;
    s_z_r[0]    <= z0_nxt;
    s_rad_r[0]  <= b_sq_re_r + b_sq_im_r;
    s_rem_r[0]  <= '0;
    s_root_r[0] <= '0;
    s_f_r[0]    <= b_flags_r;
  end

  for (genvar j = 0; j < NSTG; j++) begin : g_step
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] x_nxt;
    logic signed [CW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;
    logic signed [ZW-1:0] atan_val;
    logic                 y_pos;
    logic                 y_neg;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic [RW-1:0]        rem_nxt;
    logic [DW-1:0]        root_nxt;
    logic [SW-1:0]        rad_nxt;

    always_comb begin
      xs       = s_x_r[j] >>> j;
      ys       = s_y_r[j] >>> j;
      atan_val = $signed({{(ZW-32){1'b0}}, rtp_pkg::ATAN_TAB[j]});
      y_neg    = s_y_r[j][CW-1];
      y_pos    = !s_y_r[j][CW-1] && (s_y_r[j] != '0);
      x_nxt    = s_x_r[j];
      y_nxt    = s_y_r[j];
      z_nxt    = s_z_r[j];
      if (j < rtp_pkg::ITERATIONS) begin
        if (y_pos) begin
          x_nxt = s_x_r[j] + ys;
          y_nxt = s_y_r[j] - xs;
          z_nxt = s_z_r[j] + atan_val;
        end else if (y_neg) begin
          x_nxt = s_x_r[j] - ys;
          y_nxt = s_y_r[j] + xs;
          z_nxt = s_z_r[j] - atan_val;
        end
      end
    end

    always_comb begin
      rem_sh   = {s_rem_r[j][RW-3:0], s_rad_r[j][SW-1 -: 2]};
      trial    = {{(RW-DW-2){1'b0}}, s_root_r[j], 2'b01};
      rem_nxt  = s_rem_r[j];
      root_nxt = s_root_r[j];
      rad_nxt  = s_rad_r[j];
      if (j < rtp_pkg::SQRT_STEPS) begin
        rad_nxt = {s_rad_r[j][SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {s_root_r[j][DW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {s_root_r[j][DW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[j+1] <= 1'b0;
      end else begin
        s_v_r[j+1] <= s_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      s_x_r[j+1]    <= x_nxt;
      s_y_r[j+1]    <= y_nxt;
      s_z_r[j+1]    <= z_nxt;
      s_rad_r[j+1]  <= rad_nxt;
      s_rem_r[j+1]  <= rem_nxt;
      s_root_r[j+1] <= root_nxt;
      s_f_r[j+1]    <= s_f_r[j];
    end
  end

  // Output stage: rounding, angle quantization, clamping and special cases.
  logic                       out_valid_r;
  logic [DW-1:0]              out_magnitude_r;
  logic signed [ANGLE_W-1:0]  out_angle_r;

  logic [DW-1:0]              mag_nxt;
  logic signed [ZW-1:0]       z_rnd;
  logic signed [ZW-1:0]       z_q;
  logic signed [ANGLE_W-1:0]  ang_clamp;
  logic signed [ANGLE_W-1:0]  angle_nxt;

  always_comb begin
    mag_nxt = s_root_r[NSTG] +
              DW'(s_rem_r[NSTG] > {{(RW-DW){1'b0}}, s_root_r[NSTG]});
    z_rnd   = s_z_r[NSTG] + rtp_pkg::ROUND_Q13;
    z_q     = z_rnd >>> rtp_pkg::QSHIFT;
    if (z_q[ZW-1]) begin
      ang_clamp = '0;
    end else if (z_q > $signed({{(ZW-ANGLE_W){1'b0}}, rtp_pkg::PI_Q13})) begin
      ang_clamp = rtp_pkg::PI_Q13;
    end else begin
      ang_clamp = z_q[ANGLE_W-1:0];
    end
    if (s_f_r[NSTG].zero) begin
      angle_nxt = '0;
    end else if (s_f_r[NSTG].im_zero) begin
      angle_nxt = s_f_r[NSTG].re_pos ? '0 : rtp_pkg::PI_Q13;
    end else if (s_f_r[NSTG].im_neg) begin
      angle_nxt = -ang_clamp;
    end else begin
      angle_nxt = ang_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    out_magnitude_r <= mag_nxt;
    out_angle_r     <= angle_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_angle     = out_angle_r;

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_angle) <= rtp_pkg::PI_Q13) &&
                  ($signed(out_angle) >= -rtp_pkg::PI_Q13))
    else $error("angle outside the range of minus pi to pi");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_magnitude == '0)) |-> (out_angle == '0))
    else $error("zero magnitude item with a nonzero angle");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s_v_r[NSTG] |=> out_valid)
    else $error("item left the step pipeline without a result");
`endif

endmodule

`default_nettype wire
